// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define LSTG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define LSTG_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lstg_pkg.sv =====
// Types and constants for the lane-shift twister generator.
package lstg_pkg;

  localparam int DATA_W = 32;
  localparam int LANES_PER_WORD = 4;

  localparam logic [DATA_W-1:0] SEED_MULT = 32'd1812433253;

  // Configuration register indexes.
  localparam logic [2:0] REG_MID    = 3'd0;
  localparam logic [2:0] REG_LSHIFT = 3'd1;
  localparam logic [2:0] REG_RSHIFT = 3'd2;
  localparam logic [2:0] REG_MASK0  = 3'd3;
  localparam logic [2:0] REG_MASK1  = 3'd4;
  localparam logic [2:0] REG_MASK2  = 3'd5;
  localparam logic [2:0] REG_MASK3  = 3'd6;

  typedef logic [LANES_PER_WORD-1:0][DATA_W-1:0] mask_set_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MIX,
    OP_ADDI,
    OP_A,
    OP_C,
    OP_BM,
    OP_BR
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [1:0] lane;
  } alu_ctrl_t;

endpackage

// ===== rtl/lane_shift_twister_generator_top.sv =====
// Top level of the lane-shift twister generator.
//
// Usage: one valid/ready input channel carries requests (req_type 0 = next
// word, 1 = reseed with seed_value); one valid/ready output channel carries
// random_word. A reseed gives no output transfer. Configuration registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// The state lives in one 32-bit RAM of 4*STATE_WORDS lanes.
// Flow: a next request without regeneration goes through a RAM read, then
// the output register; in_ready rises with out_valid, so no new request is
// taken before the current one is done. When the lane buffer is used up the
// state is regenerated first: the middle offset is reduced, then each lane
// takes four RAM reads through the single read port plus one write. A
// reseed does one multiply and one add per lane after the first.
// in_ready is high only while the sequencer is idle.
// Reset: a clearing pass writes zeros to all 4*STATE_WORDS lanes, one lane a
// cycle, with in_ready low; configuration writes are taken meanwhile.
// Stall: a finished word sits in the output register; a new request is still
// taken, and its word waits in the RAM read register until the output frees.
module lane_shift_twister_generator_top import lstg_pkg::*; #(
  parameter int STATE_WORDS = 156
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [DATA_W-1:0] seed_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] random_word,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  localparam int WW    = $clog2(STATE_WORDS);
  localparam int LANES = LANES_PER_WORD * STATE_WORDS;
  localparam int AW    = WW + 2;
  localparam int RPW   = $clog2(LANES + 1);
  localparam int MODW  = 9;
  localparam int MOD_N = (STATE_WORDS > 255) ? 256 : STATE_WORDS;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_REGEN  = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;
  localparam logic [2:0] S_SEED_W = 3'd6;
  localparam logic [2:0] S_SEED_A = 3'd7;

  // Control state.
  logic [2:0]     state;
  logic [AW-1:0]  clr_addr;
  logic [RPW-1:0] rp;
  logic [WW-1:0]  word_i;
  logic [WW-1:0]  word_b;
  logic [WW-1:0]  word_c;
  logic [1:0]     lane;
  logic [2:0]     ph;
  logic [MODW-1:0] bw;
  logic [AW-1:0]  seed_idx;

  // Configuration registers.
  logic [7:0]     mid_position;
  logic [4:0]     left_shift;
  logic [4:0]     right_shift;
  mask_set_t      mask;

  // RAM and lane unit hookup.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  alu_ctrl_t         alu_ctrl;
  logic [DATA_W-1:0] alu_din;
  logic [AW-1:0]     alu_idx;
  logic [DATA_W-1:0] alu_acc;
  logic [DATA_W-1:0] alu_result;

  logic              in_xfer;
  logic              out_free;
  logic [AW-1:0]     seed_idx_next;
  logic [WW-1:0]     word_i_next;
  logic [WW-1:0]     word_b_next;
  logic [WW-1:0]     word_c_next;

  assign in_ready      = (state == S_IDLE);
  assign in_xfer       = in_valid && in_ready;
  assign out_free      = !out_valid || out_ready;
  assign seed_idx_next = seed_idx + 1'b1;

  // Word counters wrap at the end of the state.
  assign word_i_next = (word_i == WW'(STATE_WORDS - 1)) ? '0 : word_i + 1'b1;
  assign word_b_next = (word_b == WW'(STATE_WORDS - 1)) ? '0 : word_b + 1'b1;
  assign word_c_next = (word_c == WW'(STATE_WORDS - 1)) ? '0 : word_c + 1'b1;

  lstg_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LANES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lstg_lane_alu #(
    .IDX_W (AW)
  ) u_alu (
    .clk         (clk),
    .ctrl        (alu_ctrl),
    .din         (alu_din),
    .idx         (alu_idx),
    .left_shift  (left_shift),
    .right_shift (right_shift),
    .mask        (mask),
    .acc         (alu_acc),
    .result      (alu_result)
  );

  // Datapath steering per sequencer state.
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = clr_addr;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = {word_i, lane};
    alu_ctrl.op   = OP_NONE;
    alu_ctrl.lane = lane;
    alu_din       = ram_rdata;
    alu_idx       = seed_idx_next;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        // Load the seed straight into the lane unit on a reseed transfer.
        alu_din = seed_value;
        if (in_xfer && req_type) begin
          alu_ctrl.op = OP_LOAD;
        end
      end
      S_REGEN: begin
        case (ph)
          3'd0: begin
            ram_re = 1'b1;
          end
          3'd1: begin
            ram_re      = 1'b1;
            ram_raddr   = {word_c, lane};
            alu_ctrl.op = OP_A;
          end
          3'd2: begin
            ram_re      = 1'b1;
            ram_raddr   = {word_b, lane};
            alu_ctrl.op = OP_C;
          end
          3'd3: begin
            ram_re      = 1'b1;
            ram_raddr   = {word_b, lane + 2'd1};
            alu_ctrl.op = OP_BM;
          end
          default: begin
            alu_ctrl.op = OP_BR;
            ram_we      = 1'b1;
            ram_waddr   = {word_i, lane};
            ram_wdata   = alu_result;
          end
        endcase
      end
      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = rp[AW-1:0];
      end
      S_SEED_W: begin
        ram_we    = 1'b1;
        ram_waddr = seed_idx;
        ram_wdata = alu_acc;
        if (seed_idx != AW'(LANES - 1)) begin
          alu_ctrl.op = OP_MIX;
        end
      end
      S_SEED_A: begin
        alu_ctrl.op = OP_ADDI;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rp        <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once the receiver takes it; S_OUT reloads it itself.
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(LANES - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            if (req_type) begin
              seed_idx <= '0;
              state    <= S_SEED_W;
            end else if (rp == RPW'(LANES)) begin
              bw    <= {1'b0, mid_position};
              state <= S_MOD;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_MOD: begin
          // Reduce the middle offset modulo the word count, then start the pass.
          if (bw >= MODW'(MOD_N)) begin
            bw <= bw - MODW'(MOD_N);
          end else begin
            word_i <= '0;
            word_b <= WW'(bw);
            word_c <= WW'(STATE_WORDS - 1);
            lane   <= '0;
            ph     <= '0;
            state  <= S_REGEN;
          end
        end
        S_REGEN: begin
          if (ph == 3'd4) begin
            ph   <= '0;
            lane <= lane + 2'd1;
            if (lane == 2'd3) begin
              word_i <= word_i_next;
              word_b <= word_b_next;
              word_c <= word_c_next;
              if (word_i == WW'(STATE_WORDS - 1)) begin
                rp    <= '0;
                state <= S_READ;
              end
            end
          end else begin
            ph <= ph + 3'd1;
          end
        end
        S_READ: begin
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold the read data until the output register frees.
          if (out_free) begin
            random_word <= ram_rdata;
            out_valid   <= 1'b1;
            rp          <= rp + 1'b1;
            state       <= S_IDLE;
          end
        end
        S_SEED_W: begin
          if (seed_idx == AW'(LANES - 1)) begin
            rp    <= RPW'(LANES);
            state <= S_IDLE;
          end else begin
            state <= S_SEED_A;
          end
        end
        S_SEED_A: begin
          seed_idx <= seed_idx_next;
          state    <= S_SEED_W;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_position <= 8'd37;
      left_shift   <= 5'd2;
      right_shift  <= 5'd7;
      mask[0]      <= 32'h75c43b4f;
      mask[1]      <= 32'hb47d5030;
      mask[2]      <= 32'h244d9e76;
      mask[3]      <= 32'hd7fd6406;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MID:    mid_position <= cfg_data[7:0];
        REG_LSHIFT: left_shift   <= cfg_data[4:0];
        REG_RSHIFT: right_shift  <= cfg_data[4:0];
        REG_MASK0:  mask[0]      <= cfg_data;
        REG_MASK1:  mask[1]      <= cfg_data;
        REG_MASK2:  mask[2]      <= cfg_data;
        REG_MASK3:  mask[3]      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/lstg_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lstg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lstg_lane_alu.sv =====
// Shared lane unit: seed multiply/add and regeneration XOR-shift terms.
module lstg_lane_alu import lstg_pkg::*; #(
  parameter int IDX_W = 10
) (
  input  logic              clk,
  input  alu_ctrl_t         ctrl,
  input  logic [DATA_W-1:0] din,
  input  logic [IDX_W-1:0]  idx,
  input  logic [4:0]        left_shift,
  input  logic [4:0]        right_shift,
  input  mask_set_t         mask,
  output logic [DATA_W-1:0] acc,
  output logic [DATA_W-1:0] result
);

  logic [DATA_W-1:0] mixed;

  assign mixed = acc ^ (acc >> 30);

  always_comb begin
    case (ctrl.op)
      OP_LOAD: result = din;
      OP_MIX:  result = SEED_MULT * mixed;
      OP_ADDI: result = acc + DATA_W'(idx);
      OP_A:    result = din ^ (din << left_shift);
      OP_C:    result = acc ^ din ^ (din >> right_shift);
      OP_BM:   result = acc ^ (din & mask[ctrl.lane]);
      OP_BR:   result = acc ^ din;
      default: result = acc;
    endcase
  end

  // Hold the running value between steps.
  always_ff @(posedge clk) begin
    acc <= result;
  end

endmodule

// ===== rtl/lstg_checker.sv =====
// Port-level checker for the generator top, attached by bind.
`include "assert_macros.svh"

module lstg_checker import lstg_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] random_word
);

  `LSTG_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(random_word), "stalled result changed")
  `LSTG_ASSERT(a_busy_after_take, clk, rst, in_valid && in_ready |=> !in_ready, "ready after input transfer")
  `LSTG_ASSERT(a_no_instant_result, clk, rst, in_valid && in_ready && !out_valid |=> !out_valid, "result too early")
  `LSTG_ASSERT(a_result_from_busy, clk, rst, $rose(out_valid) |-> $past(!in_ready), "result while idle")
  `LSTG_ASSERT_NR(a_reset_quiet, clk, rst |=> !out_valid && !in_ready, "not quiet after reset")

endmodule

bind lane_shift_twister_generator_top lstg_checker u_lstg_checker (.*);
